@@ rtl/core/ltnr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lagrange tensor node reorder package
// Shared widths, element shape codes, register indexes, pipeline item types
// and small lookup functions for the node reorder unit.
// ----------------------------------------------------------------------------
package ltnr_pkg;

    localparam int unsigned LTNR_ORDER_CAP   = 15;
    localparam int unsigned LTNR_IDX_W       = 12;
    localparam int unsigned LTNR_ORD_W       = 4;
    localparam int unsigned LTNR_N_W         = LTNR_ORD_W + 1;
    localparam int unsigned LTNR_RECIP_W     = 17;
    localparam int unsigned LTNR_RECIP_SHIFT = 16;
    localparam int unsigned LTNR_PROD_W      = LTNR_IDX_W + LTNR_RECIP_W;
    localparam int unsigned LTNR_QDEPTH      = 4;
    localparam int unsigned LTNR_QPTR_W      = $clog2(LTNR_QDEPTH);
    localparam int unsigned LTNR_LVL_W       = $clog2(LTNR_QDEPTH + 1);

    // Node offsets of the first edge node for squares and cubes.
    localparam logic [4:0] LTNR_SQ_BASE   = 5'd4;
    localparam logic [4:0] LTNR_CUBE_BASE = 5'd8;

    typedef enum logic [1:0] {
        SHAPE_POINT   = 2'd0,
        SHAPE_SEGMENT = 2'd1,
        SHAPE_SQUARE  = 2'd2,
        SHAPE_CUBE    = 2'd3
    } t_shape;

    localparam logic [0:0] LTNR_REG_ORDER = 1'b0;
    localparam logic [0:0] LTNR_REG_SHAPE = 1'b1;

    // Values derived from the configuration registers.
    typedef struct packed {
        t_shape                    shape;
        logic [LTNR_ORD_W-1:0]     r;
        logic [LTNR_N_W-1:0]       n;
        logic [LTNR_RECIP_W-1:0]   recip;
        logic [LTNR_ORD_W-1:0]     m;
        logic [2*LTNR_ORD_W-1:0]   mm;
    } t_cfg;

    // One classified node travelling from front to back.
    typedef struct packed {
        logic                  bad;
        logic [LTNR_ORD_W-1:0] i;
        logic [LTNR_ORD_W-1:0] j;
        logic [LTNR_ORD_W-1:0] k;
    } t_qitem;

    typedef struct packed {
        logic [LTNR_LVL_W-1:0] level;
        logic                  empty;
    } t_qstat;

    // ceil(2^16 / n); the quotient floor(x * recip / 2^16) is exact for 12-bit x.
    function automatic logic [LTNR_RECIP_W-1:0] recip_of(logic [LTNR_N_W-1:0] n);
        logic [LTNR_RECIP_W-1:0] v;
        unique case (n)
            5'd2:    v = 17'd32768;
            5'd3:    v = 17'd21846;
            5'd4:    v = 17'd16384;
            5'd5:    v = 17'd13108;
            5'd6:    v = 17'd10923;
            5'd7:    v = 17'd9363;
            5'd8:    v = 17'd8192;
            5'd9:    v = 17'd7282;
            5'd10:   v = 17'd6554;
            5'd11:   v = 17'd5958;
            5'd12:   v = 17'd5462;
            5'd13:   v = 17'd5042;
            5'd14:   v = 17'd4682;
            5'd15:   v = 17'd4370;
            5'd16:   v = 17'd4096;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // Corner numbering in the i-j plane, counterclockwise from the origin.
    function automatic logic [1:0] corner_code(logic a_nz, logic b_nz);
        logic [1:0] v;
        if (a_nz) begin
            v = b_nz ? 2'd2 : 2'd1;
        end else begin
            v = b_nz ? 2'd3 : 2'd0;
        end
        return v;
    endfunction

endpackage

@@ rtl/core/ltnr_front.sv @@
// ----------------------------------------------------------------------------
// Node reorder front end
// Accepts lattice indexes, splits them into base n digits with reciprocal
// multiplies and flags indexes beyond the element's node count.
// ----------------------------------------------------------------------------
module ltnr_front
    import ltnr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [LTNR_IDX_W-1:0] i_idx,
    input  t_qstat                i_qstat,
    output logic                  o_ready,
    output logic                  o_push,
    output t_qitem                o_item
);

    logic                  r_s1_valid;
    logic [LTNR_IDX_W-1:0] r_s1_idx;
    logic [LTNR_IDX_W-1:0] r_s1_q0;
    logic                  r_s2_valid;
    logic [LTNR_IDX_W-1:0] r_s2_q0;
    logic [LTNR_IDX_W-1:0] r_s2_q1;
    logic [LTNR_ORD_W-1:0] r_s2_i;
    logic                  r_s2_idx_nz;

    logic [LTNR_LVL_W:0]      used;
    logic                     accept;
    logic [LTNR_PROD_W-1:0]   n_prod0;
    logic [LTNR_PROD_W-1:0]   n_prod1;
    logic [LTNR_IDX_W+LTNR_N_W-1:0] back0;
    logic [LTNR_IDX_W+LTNR_N_W-1:0] back1;
    logic [LTNR_IDX_W-1:0]    rem0;
    logic [LTNR_IDX_W-1:0]    rem1;
    logic                     bad;

    // Items still in the two digit stages are counted against queue space.
    assign used    = (LTNR_LVL_W+1)'(i_qstat.level) + (LTNR_LVL_W+1)'(r_s1_valid)
                   + (LTNR_LVL_W+1)'(r_s2_valid);
    assign o_ready = (used < (LTNR_LVL_W+1)'(LTNR_QDEPTH));
    assign accept  = i_valid && o_ready;

    assign n_prod0 = LTNR_PROD_W'(i_idx) * LTNR_PROD_W'(i_cfg.recip);
    assign n_prod1 = LTNR_PROD_W'(r_s1_q0) * LTNR_PROD_W'(i_cfg.recip);
    assign back0   = (LTNR_IDX_W+LTNR_N_W)'(r_s1_q0) * (LTNR_IDX_W+LTNR_N_W)'(i_cfg.n);
    assign back1   = (LTNR_IDX_W+LTNR_N_W)'(r_s2_q1) * (LTNR_IDX_W+LTNR_N_W)'(i_cfg.n);
    assign rem0    = r_s1_idx - back0[LTNR_IDX_W-1:0];
    assign rem1    = r_s2_q0 - back1[LTNR_IDX_W-1:0];

    // q0 = idx / n and q1 = idx / n^2 give the node count test per shape.
    always_comb begin
        unique case (i_cfg.shape)
            SHAPE_POINT:   bad = r_s2_idx_nz;
            SHAPE_SEGMENT: bad = (r_s2_q0 != '0);
            SHAPE_SQUARE:  bad = (r_s2_q1 != '0);
            SHAPE_CUBE:    bad = (r_s2_q1 >= LTNR_IDX_W'(i_cfg.n));
            default:       bad = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_idx    <= i_idx;
        r_s1_q0     <= n_prod0[LTNR_RECIP_SHIFT +: LTNR_IDX_W];
        r_s2_q0     <= r_s1_q0;
        r_s2_q1     <= n_prod1[LTNR_RECIP_SHIFT +: LTNR_IDX_W];
        r_s2_i      <= rem0[LTNR_ORD_W-1:0];
        r_s2_idx_nz <= (r_s1_idx != '0);
    end

    assign o_push   = r_s2_valid;
    assign o_item.bad = bad;
    assign o_item.i   = r_s2_i;
    assign o_item.j   = rem1[LTNR_ORD_W-1:0];
    assign o_item.k   = r_s2_q1[LTNR_ORD_W-1:0];

    // An in-range node always has every digit within 0..order.
    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_item.bad) |->
            (o_item.i <= i_cfg.r) && (o_item.j <= i_cfg.r) && (o_item.k <= i_cfg.r))
        else $error("digit split produced a digit above the order");

endmodule

@@ rtl/core/ltnr_queue.sv @@
// ----------------------------------------------------------------------------
// Node reorder decoupling queue
// Small FIFO of classified nodes between the front and back ends.
// ----------------------------------------------------------------------------
module ltnr_queue
    import ltnr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    input  logic   i_pop,
    output t_qitem o_item,
    output t_qstat o_qstat
);

    t_qitem                 r_mem [LTNR_QDEPTH];
    logic [LTNR_QPTR_W-1:0] r_wptr;
    logic [LTNR_QPTR_W-1:0] r_rptr;
    logic [LTNR_LVL_W-1:0]  r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + LTNR_QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + LTNR_QPTR_W'(1);
            end
            r_level <= r_level + LTNR_LVL_W'(i_push) - LTNR_LVL_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rptr];
    assign o_qstat.level = r_level;
    assign o_qstat.empty = (r_level == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level < LTNR_LVL_W'(LTNR_QDEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_level != '0))
        else $error("queue read while empty");

endmodule

@@ rtl/core/ltnr_back.sv @@
// ----------------------------------------------------------------------------
// Node reorder back end
// Classifies each node as vertex, edge, face or interior, forms its position
// as a + m*b + m*m*c over two stages and holds it in the output register.
// ----------------------------------------------------------------------------
module ltnr_back
    import ltnr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_qitem                i_item,
    input  t_qstat                i_qstat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LTNR_IDX_W-1:0] o_pos,
    output logic                  o_bad
);

    localparam int unsigned MB_W = LTNR_ORD_W + 5;
    localparam int unsigned MC_W = 2*LTNR_ORD_W + 5;

    logic                  r_e_valid;
    logic                  r_e_bad;
    logic [4:0]            r_e_a;
    logic [4:0]            r_e_b;
    logic [4:0]            r_e_c;
    logic                  r_f_valid;
    logic                  r_f_bad;
    logic [4:0]            r_f_a;
    logic [MB_W-1:0]       r_f_mb;
    logic [MC_W-1:0]       r_f_mc;
    logic                  r_o_valid;
    logic                  r_o_bad;
    logic [LTNR_IDX_W-1:0] r_o_pos;

    logic                  advance;
    logic                  ib;
    logic                  jb;
    logic                  kb;
    logic [1:0]            corner;
    logic [4:0]            ii;
    logic [4:0]            jj;
    logic [4:0]            kk;
    logic [4:0]            n_a;
    logic [4:0]            n_b;
    logic [4:0]            n_c;
    logic [MC_W-1:0]       sum;

    assign advance = !r_o_valid || i_ready;
    assign o_pop   = advance && !i_qstat.empty;

    assign ib     = (i_item.i == '0) || (i_item.i == i_cfg.r);
    assign jb     = (i_item.j == '0) || (i_item.j == i_cfg.r);
    assign kb     = (i_item.k == '0) || (i_item.k == i_cfg.r);
    assign corner = corner_code(i_item.i != '0, i_item.j != '0);
    assign ii     = 5'(i_item.i);
    assign jj     = 5'(i_item.j);
    assign kk     = 5'(i_item.k);

    always_comb begin
        n_a = '0;
        n_b = '0;
        n_c = '0;
        unique case (i_cfg.shape)
            SHAPE_POINT: begin
                n_a = '0;
            end
            SHAPE_SEGMENT: begin
                priority if (i_item.i == '0) begin
                    n_a = 5'd0;
                end else if (i_item.i == i_cfg.r) begin
                    n_a = 5'd1;
                end else begin
                    n_a = ii + 5'd1;
                end
            end
            SHAPE_SQUARE: begin
                priority if (ib && jb) begin
                    n_a = 5'(corner);
                end else if (jb) begin
                    n_a = ii + LTNR_SQ_BASE - 5'd1;
                    n_b = (i_item.j != '0) ? 5'd2 : 5'd0;
                end else if (ib) begin
                    n_a = jj + LTNR_SQ_BASE - 5'd1;
                    n_b = (i_item.i != '0) ? 5'd1 : 5'd3;
                end else begin
                    n_a = ii + LTNR_SQ_BASE - 5'd1;
                    n_b = jj + 5'd3;
                end
            end
            SHAPE_CUBE: begin
                priority if (ib && jb && kb) begin
                    n_a = 5'(corner) + ((i_item.k != '0) ? 5'd4 : 5'd0);
                end else if (jb && kb) begin
                    n_a = ii + LTNR_CUBE_BASE - 5'd1;
                    n_b = ((i_item.j != '0) ? 5'd2 : 5'd0)
                        + ((i_item.k != '0) ? 5'd4 : 5'd0);
                end else if (ib && kb) begin
                    n_a = jj + LTNR_CUBE_BASE - 5'd1;
                    n_b = ((i_item.i != '0) ? 5'd1 : 5'd3)
                        + ((i_item.k != '0) ? 5'd4 : 5'd0);
                end else if (ib && jb) begin
                    n_a = kk + LTNR_CUBE_BASE - 5'd1;
                    n_b = 5'd8 + 5'(corner);
                end else if (ib) begin
                    // Faces start after the last of the cube's edges.
                    n_a = jj + LTNR_CUBE_BASE - 5'd1;
                    n_b = kk + 5'd11;
                    n_c = (i_item.i != '0) ? 5'd1 : 5'd0;
                end else if (jb) begin
                    n_a = ii + LTNR_CUBE_BASE - 5'd1;
                    n_b = kk + 5'd11;
                    n_c = (i_item.j != '0) ? 5'd3 : 5'd2;
                end else if (kb) begin
                    n_a = ii + LTNR_CUBE_BASE - 5'd1;
                    n_b = jj + 5'd11;
                    n_c = (i_item.k != '0) ? 5'd5 : 5'd4;
                end else begin
                    // Interior nodes follow the six faces.
                    n_a = ii + LTNR_CUBE_BASE - 5'd1;
                    n_b = jj + 5'd11;
                    n_c = kk + 5'd5;
                end
            end
            default: begin
                n_a = '0;
            end
        endcase
    end

    assign sum = MC_W'(r_f_a) + MC_W'(r_f_mb) + r_f_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_e_valid <= o_pop;
            r_f_valid <= r_e_valid;
            r_o_valid <= r_f_valid;
        end
        if (advance) begin
            r_e_bad <= i_item.bad;
            r_e_a   <= n_a;
            r_e_b   <= n_b;
            r_e_c   <= n_c;
            r_f_bad <= r_e_bad;
            r_f_a   <= r_e_a;
            r_f_mb  <= MB_W'(i_cfg.m) * MB_W'(r_e_b);
            r_f_mc  <= MC_W'(i_cfg.mm) * MC_W'(r_e_c);
            r_o_bad <= r_f_bad;
            r_o_pos <= r_f_bad ? '0 : sum[LTNR_IDX_W-1:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_pos   = r_o_pos;
    assign o_bad   = r_o_bad;

    // While the output is held, nothing inside the back end may move.
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |=>
            $stable(r_e_valid) && $stable(r_f_valid) && $stable(r_o_pos) && $stable(r_o_bad))
        else $error("back end advanced during an output stall");

endmodule

@@ rtl/core/lagrange_tensor_node_reorder_unit.sv @@
// ----------------------------------------------------------------------------
// Lagrange tensor node reorder unit
// Maps lexicographic node indexes of point, segment, square and cube Lagrange
// elements to vertex-edge-face-interior order, one index per clock while the queue has space.
// ----------------------------------------------------------------------------
// The unit takes one lattice index per clock cycle on the input stream while
// it has queue space, and returns one transaction per index on the output
// stream, in order. With no back-pressure the sustained rate of one
// transaction per cycle is set by the pipelined reciprocal multiplies of the
// digit split in the front end and the two-stage multiply-add of the back end.
// A four-entry queue sits between the two, so input transactions keep flowing
// while the output waits, until the queue and the digit stages hold four
// items. Indexes at or beyond the element's node count give node_position zero
// with bad_index set. The order and shape registers are to be written over the
// APB port only while the unit is idle, which the unit does not enforce. An
// order above ORDER_CAP is treated as ORDER_CAP, and order zero is a one-node
// element. There is no reset sweep: the unit is ready right after reset.
// ----------------------------------------------------------------------------
module lagrange_tensor_node_reorder_unit
    import ltnr_pkg::*;
#(
    parameter int unsigned ORDER_CAP = LTNR_ORDER_CAP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port: order at byte address 0, shape_mode at 4.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream. tdata: [11:0] lattice_index, [15:12] zero.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Output stream. tdata: [11:0] node_position, [15:12] zero.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser: [0] bad_index.
    output logic [0:0]  m_axis_tuser
);

    logic [LTNR_ORD_W-1:0]   r_order;
    t_shape                  r_shape;
    logic [2*LTNR_ORD_W-1:0] r_mm;

    logic [LTNR_ORD_W-1:0] eff_order;
    logic [LTNR_ORD_W-1:0] m_val;
    t_cfg                  cfg;
    logic                  cfg_write;
    t_qitem                push_item;
    t_qitem                pop_item;
    t_qstat                qstat;
    logic                  push;
    logic                  pop;
    logic [LTNR_IDX_W-1:0] out_pos;
    logic                  out_bad;

    // The APB port has no wait states; a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= LTNR_ORD_W'(1);
            r_shape <= SHAPE_CUBE;
        end else if (cfg_write) begin
            unique case (paddr[2])
                LTNR_REG_ORDER: r_order <= pwdata[LTNR_ORD_W-1:0];
                LTNR_REG_SHAPE: r_shape <= t_shape'(pwdata[1:0]);
                default:        r_order <= r_order;
            endcase
        end
        // m*m is registered; it is only needed in the back end, after any write lands.
        r_mm <= (2*LTNR_ORD_W)'(m_val) * (2*LTNR_ORD_W)'(m_val);
    end

    always_comb begin
        unique case (paddr[2])
            LTNR_REG_ORDER: prdata = 32'(r_order);
            LTNR_REG_SHAPE: prdata = 32'(r_shape);
            default:        prdata = '0;
        endcase
    end

    // Orders above the supported maximum are saturated.
    assign eff_order = (int'(r_order) > int'(ORDER_CAP)) ? LTNR_ORD_W'(ORDER_CAP) : r_order;
    assign m_val     = eff_order - LTNR_ORD_W'(1);

    assign cfg.shape = r_shape;
    assign cfg.r     = eff_order;
    assign cfg.n     = LTNR_N_W'(eff_order) + LTNR_N_W'(1);
    assign cfg.recip = recip_of(cfg.n);
    assign cfg.m     = m_val;
    assign cfg.mm    = r_mm;

    ltnr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .i_idx   (s_axis_tdata[LTNR_IDX_W-1:0]),
        .i_qstat (qstat),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_item  (push_item)
    );

    ltnr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_qstat (qstat)
    );

    ltnr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (pop_item),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pos   (out_pos),
        .o_bad   (out_bad)
    );

    assign m_axis_tdata = 16'(out_pos);
    assign m_axis_tuser = out_bad;

endmodule

@@ sim/lagrange_tensor_node_reorder_unit_test.sv @@
// ----------------------------------------------------------------------------
// Lagrange tensor node reorder unit test
// Feeds lattice indexes through the stream port under random gaps and output
// stalls. It changes order and shape over the register port between phases,
// and checks each output against the table or a local node-ordering predictor.
// ----------------------------------------------------------------------------
module lagrange_tensor_node_reorder_unit_test
    import ltnr_pkg::*;
();

    localparam int unsigned TIMEOUT_CYCLES = 1000000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned NUM_PHASES     = 14;
    localparam int unsigned PHASE_ITEMS    = 100;

    // One expected output transaction.
    typedef struct packed {
        logic        bad;
        logic [11:0] pos;
    } t_node_result;

    // One directed stimulus row. When known is set, pos and bad are the
    // expected result; otherwise the predictor supplies it.
    typedef struct packed {
        logic [3:0]  ord;
        t_shape      shp;
        logic [11:0] idx;
        logic        known;
        logic [11:0] pos;
        logic        bad;
    } t_directed_row;

    localparam int unsigned NUM_DIRECTED = 25;
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Reset configuration: order 1 cube.
        '{4'd1,  SHAPE_CUBE,    12'd0,    1'b1, 12'd0, 1'b0},
        '{4'd1,  SHAPE_CUBE,    12'd7,    1'b1, 12'd6, 1'b0},
        '{4'd1,  SHAPE_CUBE,    12'd8,    1'b1, 12'd0, 1'b1},
        '{4'd1,  SHAPE_CUBE,    12'd4095, 1'b1, 12'd0, 1'b1},
        // Order zero collapses to a single node.
        '{4'd0,  SHAPE_CUBE,    12'd0,    1'b1, 12'd0, 1'b0},
        '{4'd0,  SHAPE_CUBE,    12'd1,    1'b1, 12'd0, 1'b1},
        // A point has only node zero, whatever the order.
        '{4'd9,  SHAPE_POINT,   12'd0,    1'b1, 12'd0, 1'b0},
        '{4'd9,  SHAPE_POINT,   12'd1,    1'b1, 12'd0, 1'b1},
        '{4'd9,  SHAPE_POINT,   12'd4095, 1'b1, 12'd0, 1'b1},
        // Segment at the highest order: both ends, the middle, one past; then order zero.
        '{4'd15, SHAPE_SEGMENT, 12'd0,    1'b1, 12'd0, 1'b0},
        '{4'd15, SHAPE_SEGMENT, 12'd15,   1'b1, 12'd1, 1'b0},
        '{4'd15, SHAPE_SEGMENT, 12'd7,    1'b0, 12'd0, 1'b0},
        '{4'd15, SHAPE_SEGMENT, 12'd16,   1'b1, 12'd0, 1'b1},
        '{4'd0,  SHAPE_SEGMENT, 12'd0,    1'b1, 12'd0, 1'b0},
        '{4'd0,  SHAPE_SEGMENT, 12'd1,    1'b1, 12'd0, 1'b1},
        // Square at the highest order: far corners, one past, an inner and an edge node.
        '{4'd15, SHAPE_SQUARE,  12'd255,  1'b1, 12'd2, 1'b0},
        '{4'd15, SHAPE_SQUARE,  12'd15,   1'b1, 12'd1, 1'b0},
        '{4'd15, SHAPE_SQUARE,  12'd256,  1'b1, 12'd0, 1'b1},
        '{4'd15, SHAPE_SQUARE,  12'd17,   1'b0, 12'd0, 1'b0},
        '{4'd15, SHAPE_SQUARE,  12'd16,   1'b0, 12'd0, 1'b0},
        // Cube at the highest order fills the whole index range.
        '{4'd15, SHAPE_CUBE,    12'd4095, 1'b1, 12'd6, 1'b0},
        '{4'd15, SHAPE_CUBE,    12'd4080, 1'b1, 12'd7, 1'b0},
        '{4'd15, SHAPE_CUBE,    12'd2730, 1'b0, 12'd0, 1'b0},
        '{4'd15, SHAPE_CUBE,    12'd1365, 1'b0, 12'd0, 1'b0},
        '{4'd15, SHAPE_CUBE,    12'd17,   1'b0, 12'd0, 1'b0}
    };

    // The first random phases pin the extreme settings; the rest are random.
    localparam int unsigned NUM_FIXED_PHASES = 5;
    localparam logic [3:0] FIXED_ORDERS [NUM_FIXED_PHASES] = '{4'd15, 4'd0, 4'd1, 4'd15, 4'd1};
    localparam t_shape FIXED_SHAPES [NUM_FIXED_PHASES] =
        '{SHAPE_CUBE, SHAPE_SQUARE, SHAPE_SEGMENT, SHAPE_POINT, SHAPE_CUBE};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [11:0] lattice_index, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [11:0] node_position, [15:12] zero
    logic [0:0]  m_axis_tuser;   // [0] bad_index

    // Results still owed by the unit, oldest first.
    t_node_result pending_nodes[$];
    int unsigned  failures;
    // Configuration as the unit holds it.
    logic [3:0]   cur_order;
    t_shape       cur_shape;
    // When set, neither side idles, so the pipeline runs at full rate.
    bit           steady_flow;

    lagrange_tensor_node_reorder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Number of nodes in the element; an order above the maximum saturates.
    function automatic int unsigned node_count(logic [3:0] ord, t_shape shp);
        int unsigned n;
        int unsigned cnt;
        n = ((ord > LTNR_ORDER_CAP) ? LTNR_ORDER_CAP : ord) + 1;
        case (shp)
            SHAPE_POINT:   cnt = 1;
            SHAPE_SEGMENT: cnt = n;
            SHAPE_SQUARE:  cnt = n * n;
            default:       cnt = n * n * n;
        endcase
        return cnt;
    endfunction

    // Vertices of a face in the i-j plane, counterclockwise from the origin.
    function automatic int unsigned vertex_id(bit i_far, bit j_far);
        return i_far ? (j_far ? 2 : 1) : (j_far ? 3 : 0);
    endfunction

    // Hierarchical position of one lexicographic node: vertices, then edges,
    // then faces, then interior nodes.
    function automatic t_node_result reorder_node(logic [3:0] ord, t_shape shp,
                                                  logic [11:0] idx);
        int unsigned r, n, m, i, j, k, nb, pos, face_base;
        bit ib, jb, kb;
        t_node_result res;
        r = (ord > LTNR_ORDER_CAP) ? LTNR_ORDER_CAP : ord;
        n = r + 1;
        m = r - 1;
        res = '0;
        if (idx >= node_count(ord, shp)) begin
            res.bad = 1'b1;
            return res;
        end
        i = idx % n;
        j = (idx / n) % n;
        k = idx / (n * n);
        ib = (i == 0) || (i == r);
        jb = (j == 0) || (j == r);
        kb = (k == 0) || (k == r);
        nb = 0;
        if (ib) nb++;
        if (jb) nb++;
        if (kb) nb++;
        face_base = 8 + 12 * m;
        case (shp)
            SHAPE_POINT: begin
                pos = idx;
            end
            SHAPE_SEGMENT: begin
                pos = (idx == 0) ? 0 : ((idx == r) ? 1 : idx + 1);
            end
            SHAPE_SQUARE: begin
                if (ib && jb) begin
                    pos = vertex_id(i != 0, j != 0);
                end else if (jb) begin
                    pos = 4 + (i - 1) + ((j != 0) ? 2 * m : 0);
                end else if (ib) begin
                    pos = 4 + (j - 1) + ((i != 0) ? m : 3 * m);
                end else begin
                    pos = 4 + 4 * m + (i - 1) + m * (j - 1);
                end
            end
            default: begin
                if (nb == 3) begin
                    pos = vertex_id(i != 0, j != 0) + ((k != 0) ? 4 : 0);
                end else if (nb == 2) begin
                    // Edge node: the one interior digit runs along the edge.
                    if (!ib) begin
                        pos = 8 + (i - 1) + ((j != 0) ? 2 * m : 0) + ((k != 0) ? 4 * m : 0);
                    end else if (!jb) begin
                        pos = 8 + (j - 1) + ((i != 0) ? m : 3 * m) + ((k != 0) ? 4 * m : 0);
                    end else begin
                        pos = 8 + 8 * m + (k - 1) + m * vertex_id(i != 0, j != 0);
                    end
                end else if (nb == 1) begin
                    // Face node: faces normal to i, then j, then k.
                    if (ib) begin
                        pos = face_base + (j - 1) + m * (k - 1) + ((i != 0) ? m * m : 0);
                    end else if (jb) begin
                        pos = face_base + 2 * m * m + (i - 1) + m * (k - 1)
                            + ((j != 0) ? m * m : 0);
                    end else begin
                        pos = face_base + 4 * m * m + (i - 1) + m * (j - 1)
                            + ((k != 0) ? m * m : 0);
                    end
                end else begin
                    pos = face_base + 6 * m * m + (i - 1) + m * ((j - 1) + m * (k - 1));
                end
            end
        endcase
        res.pos = pos[11:0];
        return res;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly legal nodes, some past the element, some anywhere.
    function automatic logic [11:0] pick_index(int unsigned cnt);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cnt >= 4096 || roll < 80) return 12'($urandom_range(0, cnt - 1));
        if (roll < 90) return 12'($urandom_range(cnt, 4095));
        return 12'($urandom_range(0, 4095));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("lagrange_tensor_node_reorder_unit_test NOT OK");
        $finish;
    end

    // Writes one register with a setup and an access phase, then reads it back.
    // Called at a falling edge; returns at a falling edge.
    task automatic write_register(input logic [0:0] sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $error("register %0d readback: expected %0h, actual %0h", sel, value, prdata);
            failures++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lets the unit run empty, then loads a new order and shape.
    task automatic set_element(input logic [3:0] ord, input t_shape shp);
        s_axis_tvalid <= 1'b0;
        while (pending_nodes.size() != 0) @(negedge i_clk);
        write_register(LTNR_REG_ORDER, 32'(ord));
        write_register(LTNR_REG_SHAPE, 32'(shp));
        cur_order = ord;
        cur_shape = shp;
    endtask

    // Offers one index, possibly after a gap, and holds it until accepted.
    // The expectation is queued as the index is offered; its result can only
    // follow the input transaction.
    task automatic send_index(input logic [11:0] idx, input t_node_result want);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, idx};
        pending_nodes.push_back(want);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Output side: ready in random runs separated by random stalls.
    initial begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // Every output transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_node_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_nodes.size() == 0) begin
                $error("output transaction with nothing expected: node_position %0d bad_index %0d",
                       m_axis_tdata[11:0], m_axis_tuser[0]);
                failures++;
            end else begin
                want = pending_nodes.pop_front();
                if (m_axis_tdata[11:0] !== want.pos) begin
                    $error("node_position: expected %0d, actual %0d", want.pos, m_axis_tdata[11:0]);
                    failures++;
                end
                if (m_axis_tuser[0] !== want.bad) begin
                    $error("bad_index: expected %0d, actual %0d", want.bad, m_axis_tuser[0]);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin
        logic [3:0]    ord;
        t_shape        shp;
        logic [11:0]   idx;
        t_directed_row row;
        failures      = 0;
        steady_flow   = 1'b0;
        cur_order     = 4'd1;
        cur_shape     = SHAPE_CUBE;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The first rows run on the reset configuration; later rows load
        // a new element whenever theirs differs from the current one.
        for (int t = 0; t < NUM_DIRECTED; t++) begin
            row = DIRECTED_ROWS[t];
            if (row.ord != cur_order || row.shp != cur_shape) begin
                set_element(row.ord, row.shp);
            end
            if (row.known) begin
                send_index(row.idx, '{bad: row.bad, pos: row.pos});
            end else begin
                send_index(row.idx, reorder_node(row.ord, row.shp, row.idx));
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_FIXED_PHASES) begin
                ord = FIXED_ORDERS[p];
                shp = FIXED_SHAPES[p];
            end else begin
                ord = 4'($urandom_range(0, 15));
                shp = t_shape'($urandom_range(0, 3));
            end
            set_element(ord, shp);
            steady_flow = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idx = pick_index(node_count(cur_order, cur_shape));
                send_index(idx, reorder_node(cur_order, cur_shape, idx));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_nodes.size() != 0) @(posedge i_clk);
        // Extra cycles catch any stray output transaction.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("lagrange_tensor_node_reorder_unit_test OK");
        end else begin
            $display("lagrange_tensor_node_reorder_unit_test NOT OK");
        end
        $finish;
    end

endmodule
